[rtl/core/battery_relay_guard_controller_core_macros.svh]
// assertion macros for the battery relay guard controller core
`ifndef BATTERY_RELAY_GUARD_CONTROLLER_CORE_MACROS_SVH
`define BATTERY_RELAY_GUARD_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define BRGC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("brgc check failed");

// next-cycle implication, checked out of reset
`define BRGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("brgc check failed");

`endif

[rtl/core/brgc_pkg.sv]
// shared constants for the battery relay guard controller core
package brgc_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);
    localparam int LEVEL_W      = 16;
    localparam int SUM_W        = LEVEL_W + $clog2(WINDOW_DEPTH);

    localparam int ADC_W    = 10;
    localparam int THR_W    = 10;
    localparam int TICK_W   = 6;
    localparam int TIMER_W  = 16;
    localparam int STEP_W   = 8;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 40;

    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_AFTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MON   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AFTER_RUN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PARK_STEP = 3'd5;

    localparam logic [THR_W-1:0]   LOW_THR_RST   = 10'd864;
    localparam logic [THR_W-1:0]   HIGH_THR_RST  = 10'd900;
    localparam logic [TICK_W-1:0]  INTERVAL_RST  = 6'd33;
    localparam logic [TICK_W-1:0]  AFTER_RUN_RST = 6'd35;
    localparam logic [TIMER_W-1:0] CUTOFF_RST    = 16'd300;
    localparam logic [STEP_W-1:0]  PARK_STEP_RST = 8'd10;

    localparam logic [LEVEL_W-1:0] WIN_FILL    = 16'hFFFF;
    localparam logic [SUM_W-1:0]   SUM_RST     = SUM_W'(WINDOW_DEPTH * 65535);
    localparam logic [TIMER_W-1:0] TIMER_MAX   = 16'hFFFF;

endpackage

[rtl/core/battery_relay_guard_controller_core.sv]
// battery relay guard controller: mode logic, windowed average and relay decisions
// results are registered in the output register, or the skid register when stalled
// throughput: one tick per cycle while s_tready is high; set by the window memory
//   read-modify-write, the oldest entry being read ahead at the next pointer
// reset: synchronous active low; registers return to defaults, window entries read
//   as 0xFFFF through per-entry valid flags, so no clearing pass is needed
`include "battery_relay_guard_controller_core_macros.svh"

module battery_relay_guard_controller_core
    import brgc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // [9:0] adc_sample, [10] engine_on, [11] park_pin, [12] button_pressed
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] relay_on, [1] power_on, [17:2] filtered_level, [19:18] mode_now,
    // [35:20] off_timer_now, [36] interval_end
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [THR_W-1:0]   low_thr_reg;
    logic [THR_W-1:0]   high_thr_reg;
    logic [TICK_W-1:0]  interval_reg;
    logic [TICK_W-1:0]  after_run_reg;
    logic [TIMER_W-1:0] cutoff_reg;
    logic [STEP_W-1:0]  park_step_reg;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic [TIMER_W-1:0] timer_reg, timer_next;
    logic               relay_reg, relay_next;
    logic               power_reg, power_next;
    logic [WINDOW_DEPTH-1:0] win_valid_reg;

    logic [LEVEL_W-1:0] win_mem [WINDOW_DEPTH];
    logic [LEVEL_W-1:0] win_rd_reg;
    logic               win_we;

    logic [M_TDATA_W-1:0] out_data_reg, skid_data_reg, res_data;
    logic                 out_valid_reg, skid_valid_reg;

    logic               s_accept, m_accept;
    logic [ADC_W-1:0]   adc_sample;
    logic               engine_on, park_pin, button_pressed;
    logic [LEVEL_W-1:0] old_entry;
    logic [SUM_W-1:0]   sum_upd;
    logic [LEVEL_W-1:0] avg_upd, avg_out;
    logic [TICK_W-1:0]  tick_inc;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_sat;
    logic [PTR_W-1:0]   ptr_inc;
    logic               ended;

    assign adc_sample     = s_tdata[ADC_W-1:0];
    assign engine_on      = s_tdata[ADC_W];
    assign park_pin       = s_tdata[ADC_W+1];
    assign button_pressed = s_tdata[ADC_W+2];

    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_accept  = out_valid_reg && m_tready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg   <= LOW_THR_RST;
            high_thr_reg  <= HIGH_THR_RST;
            interval_reg  <= INTERVAL_RST;
            after_run_reg <= AFTER_RUN_RST;
            cutoff_reg    <= CUTOFF_RST;
            park_step_reg <= PARK_STEP_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_LOW_THR:   low_thr_reg   <= cfg_data[THR_W-1:0];
                CFG_HIGH_THR:  high_thr_reg  <= cfg_data[THR_W-1:0];
                CFG_INTERVAL:  interval_reg  <= cfg_data[TICK_W-1:0];
                CFG_AFTER_RUN: after_run_reg <= cfg_data[TICK_W-1:0];
                CFG_CUTOFF:    cutoff_reg    <= cfg_data[TIMER_W-1:0];
                CFG_PARK_STEP: park_step_reg <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // window read of the oldest entry, prefetched at the next pointer
    assign old_entry = win_valid_reg[ptr_reg] ? win_rd_reg : WIN_FILL;
    assign sum_upd   = sum_reg - SUM_W'(old_entry) + SUM_W'(adc_sample);
    assign avg_upd   = LEVEL_W'(sum_upd / WINDOW_DEPTH);
    assign avg_out   = LEVEL_W'(sum_next / WINDOW_DEPTH);
    assign tick_inc  = tick_reg + TICK_W'(1);
    assign ptr_inc   = (ptr_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_reg + PTR_W'(1);
    assign timer_sum = {1'b0, timer_reg}
                     + (park_pin ? (TIMER_W+1)'(1) : (TIMER_W+1)'(park_step_reg));
    assign timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];

    always_comb begin
        mode_next  = mode_reg;
        sum_next   = sum_reg;
        ptr_next   = ptr_reg;
        tick_next  = tick_reg;
        timer_next = timer_reg;
        relay_next = relay_reg;
        power_next = power_reg;
        win_we     = 1'b0;
        ended      = 1'b0;
        if (s_accept) begin
            power_next = power_reg ^ button_pressed;
            case (mode_reg)
                MODE_RUN: begin
                    if (engine_on) begin
                        timer_next = '0;
                    end else begin
                        mode_next = MODE_AFTER;
                        tick_next = '0;
                    end
                end
                MODE_AFTER: begin
                    if (engine_on) begin
                        mode_next  = MODE_RUN;
                        timer_next = '0;
                        relay_next = 1'b1;
                        power_next = 1'b1;
                        tick_next  = '0;
                    end else if (tick_inc >= after_run_reg || tick_inc == '0) begin
                        mode_next  = MODE_MON;
                        relay_next = 1'b0;
                        tick_next  = '0;
                    end else begin
                        tick_next = tick_inc;
                    end
                end
                default: begin
                    if (engine_on) begin
                        mode_next  = MODE_RUN;
                        timer_next = '0;
                        relay_next = 1'b1;
                        power_next = 1'b1;
                        tick_next  = '0;
                    end else begin
                        win_we   = 1'b1;
                        sum_next = sum_upd;
                        ptr_next = ptr_inc;
                        if (tick_inc >= interval_reg || tick_inc == '0) begin
                            ended     = 1'b1;
                            tick_next = '0;
                            if (avg_upd < LEVEL_W'(low_thr_reg)) begin
                                if (relay_reg) begin
                                    relay_next = 1'b0;
                                    power_next = 1'b0;
                                end else begin
                                    relay_next = 1'b1;
                                end
                            end else if (avg_upd < LEVEL_W'(high_thr_reg)) begin
                                relay_next = 1'b1;
                            end else if (avg_upd > LEVEL_W'(high_thr_reg)) begin
                                relay_next = 1'b0;
                            end
                            timer_next = timer_sat;
                            if (timer_sat >= cutoff_reg) begin
                                relay_next = 1'b0;
                                power_next = 1'b0;
                            end
                        end else begin
                            tick_next = tick_inc;
                        end
                    end
                end
            endcase
        end
    end

    assign res_data = {3'b000, ended, timer_next, mode_next, avg_out, power_next, relay_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_MON;
            sum_reg       <= SUM_RST;
            ptr_reg       <= '0;
            tick_reg      <= '0;
            timer_reg     <= '0;
            relay_reg     <= 1'b0;
            power_reg     <= 1'b0;
            win_valid_reg <= '0;
        end else begin
            mode_reg  <= mode_next;
            sum_reg   <= sum_next;
            ptr_reg   <= ptr_next;
            tick_reg  <= tick_next;
            timer_reg <= timer_next;
            relay_reg <= relay_next;
            power_reg <= power_next;
            if (win_we) begin
                win_valid_reg[ptr_reg] <= 1'b1;
            end
        end
    end

    // window memory
    always_ff @(posedge aclk) begin
        if (win_we) begin
            win_mem[ptr_reg] <= LEVEL_W'(adc_sample);
        end
        win_rd_reg <= win_mem[ptr_next];
    end

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_accept) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= s_accept;
            end
        end else if (s_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_accept) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (s_accept) begin
                out_data_reg <= res_data;
            end
        end else if (s_accept) begin
            skid_data_reg <= res_data;
        end
    end

    `BRGC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `BRGC_ASSERT_NOW(a_run_relay_on, mode_reg == MODE_RUN, relay_reg)
    `BRGC_ASSERT_NOW(a_run_tick_clear, mode_reg == MODE_RUN, tick_reg == '0)
    `BRGC_ASSERT_NEXT(a_mon_ptr_moves, s_accept && mode_reg == MODE_MON && !engine_on,
                      ptr_reg != $past(ptr_reg))

endmodule
